// ----- hdl/minmax_stretch_quantizer_core_macros.svh -----
// Assertion macros for the min/max stretch quantizer.
// In synthesis the macros expand to nothing.
`ifndef MINMAX_STRETCH_QUANTIZER_CORE_MACROS_SVH
`define MINMAX_STRETCH_QUANTIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define MSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MSQ_ASSERT_IMP(label, ante, cons, msg) \
  `MSQ_ASSERT(label, (ante) |-> (cons), msg)

`else

`define MSQ_ASSERT(label, prop, msg)

`define MSQ_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

// ----- hdl/msq_pkg.sv -----
package msq_pkg;

  // Default pixel width.
  localparam int PixelBitsDef = 8;

  // Width and reset value of the result_bits register.
  localparam int RbitsW = 4;
  localparam logic [RbitsW-1:0] RbitsRst = 4'd8;

  // Item kinds carried in tuser bit 0.
  localparam logic KindMeasure  = 1'b0;
  localparam logic KindQuantize = 1'b1;

endpackage

// ----- hdl/minmax_stretch_quantizer_core.sv -----
// Channel     Dir  tdata (low bit up)   tuser (low bit up)
// s_axis      in   pixel                kind, first
// m_axis      out  quantized            -
// cfg         in   result_bits          -
//
// A measure beat updates min and max at once when it is taken.
// A quantize beat is taken, then the numerator is set up, then PIXEL_BITS
// restoring division steps run with a serial shift-add multiply by the step
// size, and then the output register is loaded once it is free.
// Pass-through and empty-span beats skip the division.
// Reset gives min all ones, max zero, result_bits 8. A stalled output holds
// the result in the output register while the next input beat is accepted.
`include "minmax_stretch_quantizer_core_macros.svh"

module minmax_stretch_quantizer_core
  import msq_pkg::*;
#(
  parameter int PIXEL_BITS = PixelBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [RbitsW-1:0]                     cfg_wdata_i,   // result_bits
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_axis_tdata,  // pixel
  input  logic [1:0]                            s_axis_tuser,  // kind, first
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_axis_tdata   // quantized
);

  localparam int P    = PIXEL_BITS;
  localparam int TW   = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int NW   = 2 * P + 1;
  localparam int CntW = $clog2(PIXEL_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(PIXEL_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [RbitsW-1:0] rbits_q;
  logic [P-1:0]      fmin_q, fmax_q, fmin_d, fmax_d;
  logic [P-1:0]      pix_q;
  logic [P:0]        rem_q, rem_d;
  logic [P:0]        div_q, div_d;
  logic [P-1:0]      nlo_q, nlo_d;
  logic [P-1:0]      step_q, step_d;
  logic [P-1:0]      acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              mvalid_q, mvalid_d;
  logic [P-1:0]      mdata_q, mdata_d;

  logic         in_fire, out_fire, out_free;
  logic         in_kind, in_first;
  logic [P-1:0] in_pix;
  logic         pass, empty;
  logic [P-1:0] pclamp, span, offs;
  logic [2*P-1:0] dsh, lm1d;
  logic [NW-1:0]  num;
  logic [P+1:0]   cand;
  logic [P+2:0]   diff;
  logic           qbit;

  assign in_kind  = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_pix   = s_axis_tdata[P-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = mvalid_q && m_axis_tready;
  assign out_free      = !mvalid_q || m_axis_tready;

  // Numerator of the rounded quotient: 2*(L-1)*d + span, with (L-1)*d as a shift and subtract.
  assign pass   = (32'(rbits_q) >= 32'(PIXEL_BITS));
  assign empty  = (fmax_q <= fmin_q);
  assign pclamp = (pix_q < fmin_q) ? fmin_q : ((pix_q > fmax_q) ? fmax_q : pix_q);
  assign span   = fmax_q - fmin_q;
  assign offs   = pclamp - fmin_q;
  assign dsh    = {{P{1'b0}}, offs} << rbits_q;
  assign lm1d   = dsh - {{P{1'b0}}, offs};
  assign num    = {lm1d, 1'b0} + {{(P+1){1'b0}}, span};

  // One restoring division step against 2*span.
  assign cand = {rem_q, nlo_q[P-1]};
  assign diff = {1'b0, cand} - {2'b00, div_q};
  assign qbit = !diff[P+2];

  always_comb begin
    state_d  = state_q;
    fmin_d   = fmin_q;
    fmax_d   = fmax_q;
    rem_d    = rem_q;
    div_d    = div_q;
    nlo_d    = nlo_q;
    step_d   = step_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;

    if (out_fire) begin
      mvalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KindMeasure) begin
            if (in_first) begin
              fmin_d = in_pix;
              fmax_d = in_pix;
            end else begin
              if (in_pix < fmin_q) fmin_d = in_pix;
              if (in_pix > fmax_q) fmax_d = in_pix;
            end
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (pass) begin
          acc_d   = pix_q;
          state_d = ST_EMIT;
        end else if (empty) begin
          acc_d   = '0;
          state_d = ST_EMIT;
        end else begin
          rem_d   = num[NW-1:P];
          nlo_d   = num[P-1:0];
          div_d   = {span, 1'b0};
          step_d  = fmax_q >> rbits_q;
          acc_d   = '0;
          cnt_d   = CntLast;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        rem_d = qbit ? diff[P:0] : cand[P:0];
        nlo_d = {nlo_q[P-2:0], 1'b0};
        // Quotient bits arrive MSB first, so the product builds up by shift and add.
        acc_d = {acc_q[P-2:0], 1'b0} + (qbit ? step_q : '0);
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mdata_d  = acc_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rbits_q  <= RbitsRst;
      fmin_q   <= '1;
      fmax_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fmin_q   <= fmin_d;
      fmax_q   <= fmax_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) begin
        rbits_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= in_pix;
    end
    rem_q   <= rem_d;
    div_q   <= div_d;
    nlo_q   <= nlo_d;
    step_q  <= step_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = TW'(mdata_q);

  `MSQ_ASSERT_IMP(a_quant_to_load, in_fire && (in_kind == KindQuantize),
                  ##1 (state_q == ST_LOAD), "quantize beat did not start setup")
  `MSQ_ASSERT_IMP(a_first_restarts, in_fire && (in_kind == KindMeasure) && in_first,
                  ##1 (fmin_q == fmax_q), "first beat did not restart min and max")
  `MSQ_ASSERT_IMP(a_rem_below_div, state_q == ST_DIVIDE, rem_q < div_q,
                  "division remainder out of range")
  `MSQ_ASSERT_IMP(a_div_runs, (state_q == ST_DIVIDE) && (cnt_q != '0),
                  ##1 (state_q == ST_DIVIDE), "division ended early")

endmodule
